// File: rtl/bgf_pkg.sv
// ----------------------------------------------------------------------------
// bgf_pkg
// Shared widths, register indexes, curve tables and control types for the
// battery gauge filter.
// ----------------------------------------------------------------------------
package bgf_pkg;

  // field widths
  localparam int ADC_W   = 12;
  localparam int MV_W    = 14;
  localparam int PCT_W   = 10;
  localparam int SCALE_W = 16;
  localparam int ALPHA_W = 16;
  localparam int STEP_W  = 10;
  localparam int CFG_W   = 16;
  localparam int CFG_A_W = 2;

  // fixed point formats of the gain and the average weight
  localparam int SCALE_FRAC = 12;
  localparam int ALPHA_FRAC = 16;

  // default fraction bits of the smoothed voltage
  localparam int EMA_FRACTION_BITS = 16;

  localparam logic [MV_W-1:0]  MV_MAX     = 14'd16383;
  localparam logic [PCT_W-1:0] PCT_FULL   = 10'd1000;
  localparam logic [MV_W-1:0]  CURVE_TOP  = 14'd4200;
  localparam logic [MV_W-1:0]  CURVE_BOT  = 14'd3270;

  // register indexes
  localparam logic [CFG_A_W-1:0] REG_SCALE = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_ALPHA = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_STEP  = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd14623;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd9830;
  localparam logic [STEP_W-1:0]  STEP_RST  = 10'd5;

  // voltage curve, top down
  localparam int CURVE_SEGMENTS = 20;
  localparam int CURVE_PTS      = CURVE_SEGMENTS + 1;

  localparam logic [MV_W-1:0] CURVE_MV [CURVE_PTS] = '{
    14'd4200, 14'd4150, 14'd4110, 14'd4080, 14'd4020,
    14'd3980, 14'd3950, 14'd3910, 14'd3870, 14'd3850,
    14'd3840, 14'd3820, 14'd3800, 14'd3790, 14'd3770,
    14'd3750, 14'd3730, 14'd3710, 14'd3690, 14'd3610, 14'd3270
  };
  localparam logic [PCT_W-1:0] CURVE_TENTHS [CURVE_PTS] = '{
    10'd1000, 10'd950, 10'd900, 10'd850, 10'd800,
    10'd750,  10'd700, 10'd650, 10'd600, 10'd550,
    10'd500,  10'd450, 10'd400, 10'd350, 10'd300,
    10'd250,  10'd200, 10'd150, 10'd100, 10'd50, 10'd0
  };

  // quotient bits of the interpolation divide: every segment spans 50 tenths,
  // so the rounded drop stays below 64
  localparam int QUOT_W = 6;

  typedef struct packed {
    logic load;
    logic scale;
    logic ema_mul;
    logic ema_add;
    logic seg;
    logic num;
    logic div;
    logic commit;
  } bgf_cmd_t;

  typedef struct packed {
    logic out_free;
  } bgf_sts_t;

endpackage

// File: rtl/bgf_ctrl.sv
// ----------------------------------------------------------------------------
// bgf_ctrl
// Sequencer of the gauge filter: steps one sample through scale, average,
// curve lookup, divide and slew, and holds the result step until the output
// register is free.
// ----------------------------------------------------------------------------
module bgf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bgf_pkg::bgf_sts_t  sts,
  output bgf_pkg::bgf_cmd_t  cmd
);

  localparam int CNT_W = $clog2(bgf_pkg::QUOT_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_EMA_MUL,
    ST_EMA_ADD,
    ST_SEG,
    ST_NUM,
    ST_DIV,
    ST_SLEW
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_EMA_MUL;
      end
      ST_EMA_MUL: begin
        cmd.ema_mul = 1'b1;
        state_nxt   = ST_EMA_ADD;
      end
      ST_EMA_ADD: begin
        cmd.ema_add = 1'b1;
        state_nxt   = ST_SEG;
      end
      ST_SEG: begin
        cmd.seg   = 1'b1;
        state_nxt = ST_NUM;
      end
      ST_NUM: begin
        cmd.num   = 1'b1;
        cnt_nxt   = CNT_W'(bgf_pkg::QUOT_W - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = ST_SLEW;
      end
      ST_SLEW: begin
        // wait here while the previous result still sits unread
        cmd.commit = sts.out_free;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == ST_IDLE)
    else $error("controller did not return to idle after commit");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SLEW && !sts.out_free) |=> state_r == ST_SLEW)
    else $error("result step left while output register busy");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == '0) |-> $past(state_r, bgf_pkg::QUOT_W) == ST_NUM)
    else $error("divide did not run its full number of steps");

endmodule

// File: rtl/bgf_dp.sv
// ----------------------------------------------------------------------------
// bgf_dp
// Datapath of the gauge filter: config registers, gain multiply, moving
// average, curve segment select, restoring divide, slew limit and the
// output register.
// ----------------------------------------------------------------------------
module bgf_dp #(
  parameter int EMA_FRACTION_BITS = bgf_pkg::EMA_FRACTION_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bgf_pkg::bgf_cmd_t            cmd,
  output bgf_pkg::bgf_sts_t            sts,
  input  logic [bgf_pkg::ADC_W-1:0]    adc_in,
  input  logic                         cfg_we,
  input  logic [bgf_pkg::CFG_A_W-1:0]  cfg_idx,
  input  logic [bgf_pkg::CFG_W-1:0]    cfg_val,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bgf_pkg::MV_W-1:0]     out_mv,
  output logic [bgf_pkg::PCT_W-1:0]    out_pct
);

  localparam int ADC_W  = bgf_pkg::ADC_W;
  localparam int MV_W   = bgf_pkg::MV_W;
  localparam int PCT_W  = bgf_pkg::PCT_W;
  localparam int FRAC_W = EMA_FRACTION_BITS;
  localparam int SV_W   = MV_W + FRAC_W;
  localparam int SPR_W  = ADC_W + bgf_pkg::SCALE_W + 1;
  localparam int EPR_W  = SV_W + bgf_pkg::ALPHA_W;
  localparam int NUM_W  = SV_W + PCT_W;
  localparam int REM_W  = NUM_W + 1;
  localparam int QUOT_W = bgf_pkg::QUOT_W;
  localparam int SEGS   = bgf_pkg::CURVE_SEGMENTS;

  function automatic logic [SV_W-1:0] to_fix(input logic [MV_W-1:0] mv);
    to_fix = {mv, {FRAC_W{1'b0}}};
  endfunction

  // config
  logic [bgf_pkg::SCALE_W-1:0] scale_r;
  logic [bgf_pkg::ALPHA_W-1:0] alpha_r;
  logic [bgf_pkg::STEP_W-1:0]  step_r;

  // working registers
  logic [ADC_W-1:0]  adc_r;
  logic [MV_W-1:0]   mv_r;
  logic [EPR_W-1:0]  eprod_r;
  logic              edown_r;
  logic [SV_W-1:0]   sv_r;
  logic              seeded_r;
  logic              full_r, empty_r;
  logic [MV_W-1:0]   hi_mv_r, lo_mv_r;
  logic [PCT_W-1:0]  t_hi_r, span_r;
  logic [REM_W-1:0]  rem_r, den_sh_r;
  logic [QUOT_W-1:0] q_r;
  logic [PCT_W-1:0]  shown_r;
  logic              out_valid_r;
  logic [MV_W-1:0]   out_mv_r;
  logic [PCT_W-1:0]  out_pct_r;

  // gain multiply with round and saturate
  logic [SPR_W-1:0]  sprod;
  logic [SPR_W-bgf_pkg::SCALE_FRAC-1:0] srnd;
  logic [MV_W-1:0]   mv_sat;

  assign sprod  = SPR_W'(adc_r * scale_r) + SPR_W'(1 << (bgf_pkg::SCALE_FRAC - 1));
  assign srnd   = sprod[SPR_W-1:bgf_pkg::SCALE_FRAC];
  assign mv_sat = (srnd > (SPR_W-bgf_pkg::SCALE_FRAC)'(bgf_pkg::MV_MAX)) ?
                  bgf_pkg::MV_MAX : srnd[MV_W-1:0];

  // moving average
  logic [SV_W-1:0]  x_fix;
  logic [SV_W-1:0]  emag;
  logic [EPR_W:0]   esum;
  logic [SV_W-1:0]  estep;

  assign x_fix = to_fix(mv_r);
  assign emag  = (x_fix >= sv_r) ? (x_fix - sv_r) : (sv_r - x_fix);
  assign esum  = {1'b0, eprod_r} + (EPR_W+1)'(1 << (bgf_pkg::ALPHA_FRAC - 1));
  assign estep = esum[bgf_pkg::ALPHA_FRAC +: SV_W];

  // segment select: first segment from the top whose low end is at or below
  logic [MV_W-1:0]  sel_hi, sel_lo;
  logic [PCT_W-1:0] sel_thi, sel_tlo;

  always_comb begin
    sel_hi  = bgf_pkg::CURVE_MV[0];
    sel_lo  = bgf_pkg::CURVE_MV[1];
    sel_thi = bgf_pkg::CURVE_TENTHS[0];
    sel_tlo = bgf_pkg::CURVE_TENTHS[1];
    for (int i = SEGS - 1; i >= 0; i--) begin
      if (sv_r >= to_fix(bgf_pkg::CURVE_MV[i+1])) begin
        sel_hi  = bgf_pkg::CURVE_MV[i];
        sel_lo  = bgf_pkg::CURVE_MV[i+1];
        sel_thi = bgf_pkg::CURVE_TENTHS[i];
        sel_tlo = bgf_pkg::CURVE_TENTHS[i+1];
      end
    end
  end

  // numerator and divisor of the interpolation
  logic [SV_W-1:0]  vdiff, den;
  logic [NUM_W-1:0] num;

  assign vdiff = to_fix(hi_mv_r) - sv_r;
  assign den   = to_fix(hi_mv_r) - to_fix(lo_mv_r);
  assign num   = NUM_W'(vdiff * span_r);

  // target and slew limit
  logic [PCT_W-1:0] target, pdiff, pstep, shown_nxt;

  always_comb begin
    if (full_r)       target = bgf_pkg::PCT_FULL;
    else if (empty_r) target = '0;
    else              target = t_hi_r - PCT_W'(q_r);

    pdiff = (target > shown_r) ? (target - shown_r) : (shown_r - target);
    pstep = (pdiff > step_r) ? step_r : pdiff;

    if (!seeded_r)             shown_nxt = target;
    else if (target > shown_r) shown_nxt = shown_r + pstep;
    else                       shown_nxt = shown_r - pstep;
  end

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= bgf_pkg::SCALE_RST;
      alpha_r     <= bgf_pkg::ALPHA_RST;
      step_r      <= bgf_pkg::STEP_RST;
      sv_r        <= '0;
      shown_r     <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          bgf_pkg::REG_SCALE: scale_r <= cfg_val[bgf_pkg::SCALE_W-1:0];
          bgf_pkg::REG_ALPHA: alpha_r <= cfg_val[bgf_pkg::ALPHA_W-1:0];
          bgf_pkg::REG_STEP:  step_r  <= cfg_val[bgf_pkg::STEP_W-1:0];
          default: ;
        endcase
      end

      if (cmd.ema_add) begin
        if (!seeded_r)   sv_r <= x_fix;
        else if (edown_r) sv_r <= sv_r - estep;
        else             sv_r <= sv_r + estep;
      end

      if (cmd.commit) begin
        shown_r  <= shown_nxt;
        seeded_r <= 1'b1;
      end

      if (cmd.commit)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load)  adc_r <= adc_in;
    if (cmd.scale) mv_r  <= mv_sat;
    if (cmd.ema_mul) begin
      eprod_r <= EPR_W'(emag * alpha_r);
      edown_r <= (x_fix < sv_r);
    end
    if (cmd.seg) begin
      full_r  <= (sv_r >= to_fix(bgf_pkg::CURVE_TOP));
      empty_r <= (sv_r <= to_fix(bgf_pkg::CURVE_BOT));
      hi_mv_r <= sel_hi;
      lo_mv_r <= sel_lo;
      t_hi_r  <= sel_thi;
      span_r  <= sel_thi - sel_tlo;
    end
    if (cmd.num) begin
      // half the divisor added up front rounds the quotient to nearest
      rem_r    <= REM_W'(num) + REM_W'(den >> 1);
      den_sh_r <= REM_W'(den) << (QUOT_W - 1);
      q_r      <= '0;
    end
    if (cmd.div) begin
      if (rem_r >= den_sh_r) begin
        rem_r <= rem_r - den_sh_r;
        q_r   <= {q_r[QUOT_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QUOT_W-2:0], 1'b0};
      end
      den_sh_r <= den_sh_r >> 1;
    end
    if (cmd.commit) begin
      out_mv_r  <= mv_r;
      out_pct_r <= shown_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_mv    = out_mv_r;
  assign out_pct   = out_pct_r;

  a_shown_range: assert property (@(posedge clk) disable iff (!rst_n)
    shown_r <= bgf_pkg::PCT_FULL)
    else $error("displayed percent out of range");

  a_drop_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && !full_r && !empty_r) |-> PCT_W'(q_r) <= span_r)
    else $error("interpolation drop exceeds segment span");

  a_ema_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ema_add && seeded_r && !edown_r) |=>
      (sv_r >= $past(sv_r) && sv_r <= $past(x_fix)))
    else $error("average left the interval between old value and sample");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(out_mv_r) && $stable(out_pct_r))
    else $error("pending result overwritten");

endmodule

// File: rtl/battery_gauge_ema_slew_filter.sv
// ----------------------------------------------------------------------------
// battery_gauge_ema_slew_filter
// Battery fuel gauge: scales a divider ADC sample, smooths it, maps it to a
// charge percentage and limits how fast the displayed charge moves.
// ----------------------------------------------------------------------------
// Each sample steps through scale, average, curve lookup, the six-step
// restoring divide of the curve interpolation and slew before its result is
// registered on the output, and a new sample is accepted in the cycle after
// that, so the block takes no new sample while one is in flight. The result
// register holds one finished beat, so the next sample is accepted while it
// waits; a held result stalls only the final step of the following sample.
// Configuration writes are always taken and must be made while no sample is
// in flight. The first sample after reset seeds both the average and the
// displayed charge.
module battery_gauge_ema_slew_filter #(
  parameter int EMA_FRACTION_BITS = bgf_pkg::EMA_FRACTION_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // slave side: [11:0] adc_millivolts, [15:12] zero
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [15:0]                  in_tdata,
  // master side: [13:0] battery_millivolts, [23:14] percent_tenths
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [23:0]                  out_tdata,
  // config writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bgf_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [bgf_pkg::CFG_W-1:0]    cfg_data
);

  bgf_pkg::bgf_cmd_t             cmd;
  bgf_pkg::bgf_sts_t             sts;
  logic [bgf_pkg::MV_W-1:0]      out_mv;
  logic [bgf_pkg::PCT_W-1:0]     out_pct;

  assign cfg_ready = 1'b1;
  assign out_tdata = {out_pct, out_mv};

  bgf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bgf_dp #(
    .EMA_FRACTION_BITS (EMA_FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .adc_in    (in_tdata[bgf_pkg::ADC_W-1:0]),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_addr),
    .cfg_val   (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_mv    (out_mv),
    .out_pct   (out_pct)
  );

endmodule
